### hdl/hbs_pkg.sv
// Shared constants and types for the histogram box smoothing block.
// No dependencies; every module of the block but hbs_queue imports this package.
package hbs_pkg;

    // Default sizing of the block
    localparam int NUM_BINS_DEF   = 256;
    localparam int MAX_RADIUS_DEF = 5;
    localparam int COUNT_BITS_DEF = 24;

    // Fixed field widths on the ports
    localparam int IN_COUNT_BITS  = 24;
    localparam int OUT_COUNT_BITS = 24;
    localparam int OUT_INDEX_BITS = 8;
    localparam int CFG_BITS       = 3;

    // Radius used after reset and for any radius outside the legal range
    localparam int DEFAULT_RADIUS = 3;

    // Depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH    = 4;

    // Position of a bin within its histogram
    typedef struct packed {
        logic first;
        logic last;
    } t_bin_flags;

    // Status of the back part, seen by the top level checks
    typedef struct packed {
        logic flushing;
        logic pop;
    } t_back_status;

endpackage

### hdl/histogram_box_smoothing.sv
// Box smoothing of a histogram: one bin count per item, one smoothed count per bin.
// Throughput: one bin per cycle unless stalled; the last bin adds r results (r = radius).
// The result for bin i goes through queue, sum and divider after bin i+r is taken.
// The queue (4 items) lets bins keep arriving while the final results drain.
// Reset: synchronous, active low; clears control state and sets the radius to 3.
module histogram_box_smoothing import hbs_pkg::*; #(
    parameter int NUM_BINS   = NUM_BINS_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_BITS-1:0]   i_cfg_data,    // smoothing_radius
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // [23:0] bin_count
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,  // [23:0] smoothed_count, [31:24] bin_index
    output logic                  m_axis_tlast   // last
);

    localparam int CB = COUNT_BITS;
    localparam int IB = $clog2(NUM_BINS);
    localparam int RB = $clog2(MAX_RADIUS + 1);
    localparam int SB = CB + $clog2(2 * MAX_RADIUS + 2);
    localparam int QW = CB + IB + RB + $bits(t_bin_flags);
    localparam int QL = $clog2(QUEUE_DEPTH + 1);

    logic                      w_q_push, w_q_full, w_q_valid, w_q_pop;
    logic [CB-1:0]             w_f_count, w_b_count;
    logic [IB-1:0]             w_f_index, w_b_index;
    logic [RB-1:0]             w_f_radius, w_b_radius;
    t_bin_flags                w_f_flags, w_b_flags;
    logic [QW-1:0]             w_q_wdata, w_q_rdata;
    logic [QL-1:0]             w_q_level;
    logic                      w_job_valid, w_job_ready, w_job_last;
    logic [SB-1:0]             w_job_sum;
    logic [RB-1:0]             w_job_radius;
    logic [OUT_INDEX_BITS-1:0] w_job_index;
    t_back_status              w_status;
    logic [OUT_COUNT_BITS-1:0] w_out_count;
    logic [OUT_INDEX_BITS-1:0] w_out_index;

    hbs_front #(
        .NUM_BINS   (NUM_BINS),
        .MAX_RADIUS (MAX_RADIUS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_s_data    (s_axis_tdata),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_count   (w_f_count),
        .o_q_index   (w_f_index),
        .o_q_radius  (w_f_radius),
        .o_q_flags   (w_f_flags)
    );

    // Pack the classified bin for the queue
    assign w_q_wdata = {w_f_flags, w_f_radius, w_f_index, w_f_count};
    assign {w_b_flags, w_b_radius, w_b_index, w_b_count} = w_q_rdata;

    hbs_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata),
        .o_level (w_q_level)
    );

    hbs_back #(
        .NUM_BINS   (NUM_BINS),
        .MAX_RADIUS (MAX_RADIUS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .o_q_pop      (w_q_pop),
        .i_q_count    (w_b_count),
        .i_q_index    (w_b_index),
        .i_q_radius   (w_b_radius),
        .i_q_flags    (w_b_flags),
        .o_job_valid  (w_job_valid),
        .i_job_ready  (w_job_ready),
        .o_job_sum    (w_job_sum),
        .o_job_radius (w_job_radius),
        .o_job_index  (w_job_index),
        .o_job_last   (w_job_last),
        .o_status     (w_status)
    );

    hbs_div #(
        .MAX_RADIUS (MAX_RADIUS),
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_job_valid),
        .o_job_ready  (w_job_ready),
        .i_job_sum    (w_job_sum),
        .i_job_radius (w_job_radius),
        .i_job_index  (w_job_index),
        .i_job_last   (w_job_last),
        .o_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .o_count      (w_out_count),
        .o_index      (w_out_index),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {w_out_index, w_out_count};

    // No new bin is taken from the queue while the final results drain
    a_flush_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.flushing |-> !w_status.pop)
        else $error("bin popped during flush");

    // The closing result carries the index of the final bin
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tdata[31:24] == OUT_INDEX_BITS'(NUM_BINS - 1)))
        else $error("last flag on a result that is not the final bin");

    // Queue fill never passes its depth
    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_level <= QL'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

endmodule

### hdl/hbs_queue.sv
// Small register queue that decouples the front part from the back part.
// Depends on nothing but its parameters.
module hbs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [WIDTH-1:0]              i_data,
    output logic                          o_full,
    input  logic                          i_pop,
    output logic                          o_valid,
    output logic [WIDTH-1:0]              o_data,
    output logic [$clog2(DEPTH+1)-1:0]    o_level
);

    localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LB = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PB-1:0]    r_wr, n_wr;
    logic [PB-1:0]    r_rd, n_rd;
    logic [LB-1:0]    r_level, n_level;
    logic             w_push, w_pop;

    assign o_full  = (r_level == LB'(DEPTH));
    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rd];
    assign o_level = r_level;

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_valid;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_level = r_level;
        if (w_push) begin
            n_wr = (r_wr == PB'(DEPTH - 1)) ? '0 : r_wr + PB'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == PB'(DEPTH - 1)) ? '0 : r_rd + PB'(1);
        end
        if (w_push && !w_pop) begin
            n_level = r_level + LB'(1);
        end else if (w_pop && !w_push) begin
            n_level = r_level - LB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

    // Store the item at the write pointer
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### hdl/hbs_front.sv
// Front part: configuration register, item accept, bin numbering and radius latch.
// Depends on hbs_pkg.
module hbs_front import hbs_pkg::*; #(
    parameter int NUM_BINS   = NUM_BINS_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [CFG_BITS-1:0]               i_cfg_data,
    input  logic                              i_s_valid,
    output logic                              o_s_ready,
    input  logic [IN_COUNT_BITS-1:0]          i_s_data,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output logic [COUNT_BITS-1:0]             o_q_count,
    output logic [$clog2(NUM_BINS)-1:0]       o_q_index,
    output logic [$clog2(MAX_RADIUS+1)-1:0]   o_q_radius,
    output t_bin_flags                        o_q_flags
);

    localparam int IB    = $clog2(NUM_BINS);
    localparam int RB    = $clog2(MAX_RADIUS + 1);
    localparam int DEF_R = (MAX_RADIUS < DEFAULT_RADIUS) ? MAX_RADIUS : DEFAULT_RADIUS;

    logic [CFG_BITS-1:0] r_cfg_radius;
    logic [IB-1:0]       r_k, n_k;
    logic [RB-1:0]       r_rad, n_rad;
    logic [RB-1:0]       w_eff_radius;
    logic                w_accept;
    logic                w_first, w_last;

    assign o_cfg_ready = 1'b1;
    assign o_s_ready   = !i_q_full;
    assign w_accept    = i_s_valid && !i_q_full;

    // Map an illegal radius onto the default
    assign w_eff_radius = ((r_cfg_radius == '0) ||
                           ((CFG_BITS + 1)'(r_cfg_radius) > (CFG_BITS + 1)'(MAX_RADIUS)))
                          ? RB'(DEF_R) : RB'(r_cfg_radius);

    assign w_first = (r_k == '0);
    assign w_last  = (r_k == IB'(NUM_BINS - 1));

    // Latch the radius on the first bin and number the bins
    always_comb begin
        n_k   = r_k;
        n_rad = r_rad;
        if (w_accept) begin
            n_k = w_last ? '0 : r_k + IB'(1);
            if (w_first) begin
                n_rad = w_eff_radius;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_radius <= CFG_BITS'(DEFAULT_RADIUS);
            r_k          <= '0;
            r_rad        <= RB'(DEF_R);
        end else begin
            if (i_cfg_valid) begin
                r_cfg_radius <= i_cfg_data;
            end
            r_k   <= n_k;
            r_rad <= n_rad;
        end
    end

    // Hand the classified item to the queue
    assign o_q_push        = w_accept;
    assign o_q_count       = COUNT_BITS'(i_s_data);
    assign o_q_index       = r_k;
    assign o_q_radius      = w_first ? w_eff_radius : r_rad;
    assign o_q_flags.first = w_first;
    assign o_q_flags.last  = w_last;

endmodule

### hdl/hbs_back.sv
// Back part: delay line, running window sum and the end-of-histogram flush.
// Depends on hbs_pkg; feeds sums to hbs_div.
module hbs_back import hbs_pkg::*; #(
    parameter int NUM_BINS   = NUM_BINS_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_q_valid,
    output logic                                            o_q_pop,
    input  logic [COUNT_BITS-1:0]                           i_q_count,
    input  logic [$clog2(NUM_BINS)-1:0]                     i_q_index,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]                 i_q_radius,
    input  t_bin_flags                                      i_q_flags,
    output logic                                            o_job_valid,
    input  logic                                            i_job_ready,
    output logic [COUNT_BITS+$clog2(2*MAX_RADIUS+2)-1:0]    o_job_sum,
    output logic [$clog2(MAX_RADIUS+1)-1:0]                 o_job_radius,
    output logic [OUT_INDEX_BITS-1:0]                       o_job_index,
    output logic                                            o_job_last,
    output t_back_status                                    o_status
);

    localparam int CB = COUNT_BITS;
    localparam int IB = $clog2(NUM_BINS);
    localparam int RB = $clog2(MAX_RADIUS + 1);
    localparam int LD = 2 * MAX_RADIUS + 1;
    localparam int LB = $clog2(LD);
    localparam int DB = $clog2(2 * MAX_RADIUS + 2);
    localparam int SB = CB + DB;
    localparam int CW = ((IB > LB) ? IB : LB) + 1;

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_FLUSH = 2'b10
    } t_back_state;

    t_back_state   r_state, n_state;
    logic [CB-1:0] r_line [LD];
    logic [CB-1:0] r_first;
    logic [SB-1:0] r_wsum;
    logic [RB-1:0] r_t;
    logic [IB-1:0] r_k;
    logic [RB-1:0] r_r;

    logic [DB-1:0] w_in_div;
    logic [LB-1:0] w_in_sel;
    logic [CB-1:0] w_in_old;
    logic [SB-1:0] w_in_wsum;
    logic          w_in_emit;
    logic [LB-1:0] w_fl_sel;
    logic [CB-1:0] w_fl_old;
    logic [SB-1:0] w_fl_wsum;
    logic          w_fl_last;
    logic          w_pop;
    logic          w_fl_step;

    // Running sum for a newly arrived bin: add it, drop the bin 2r+1 back
    assign w_in_div  = DB'({i_q_radius, 1'b1});
    assign w_in_sel  = LB'({i_q_radius, 1'b0});
    assign w_in_old  = (CW'(i_q_index) >= CW'({i_q_radius, 1'b0}) + CW'(1))
                       ? r_line[w_in_sel] : r_first;
    assign w_in_wsum = i_q_flags.first ? SB'(i_q_count) * SB'(w_in_div)
                       : r_wsum + SB'(i_q_count) - SB'(w_in_old);
    assign w_in_emit = (CW'(i_q_index) >= CW'(i_q_radius));

    // Flush step: the last bin repeats past the high edge
    assign w_fl_sel  = LB'({r_r, 1'b0}) - LB'(r_t) + LB'(1);
    assign w_fl_old  = (CW'(r_k) >= CW'(w_fl_sel)) ? r_line[w_fl_sel] : r_first;
    assign w_fl_wsum = r_wsum + SB'(r_line[0]) - SB'(w_fl_old);
    assign w_fl_last = (r_t == r_r);

    // Sequence normal bins and the flush of the final results
    always_comb begin
        n_state      = r_state;
        w_pop        = 1'b0;
        w_fl_step    = 1'b0;
        o_job_valid  = 1'b0;
        o_job_sum    = w_in_wsum + SB'(i_q_radius);
        o_job_radius = i_q_radius;
        o_job_index  = OUT_INDEX_BITS'(i_q_index - IB'(i_q_radius));
        o_job_last   = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                o_job_valid = i_q_valid && w_in_emit;
                w_pop       = i_q_valid && i_job_ready;
                if (w_pop && i_q_flags.last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                o_job_valid  = 1'b1;
                o_job_sum    = w_fl_wsum + SB'(r_r);
                o_job_radius = r_r;
                o_job_index  = OUT_INDEX_BITS'(r_k - IB'(r_r) + IB'(r_t));
                o_job_last   = w_fl_last;
                w_fl_step    = i_job_ready;
                if (i_job_ready && w_fl_last) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    assign o_q_pop           = w_pop;
    assign o_status.flushing = (r_state == ST_FLUSH);
    assign o_status.pop      = w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // Shift the delay line and keep the window sum
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_line[0] <= i_q_count;
            for (int d = 1; d < LD; d++) begin
                r_line[d] <= r_line[d-1];
            end
            if (i_q_flags.first) begin
                r_first <= i_q_count;
            end
            r_wsum <= w_in_wsum;
            r_t    <= RB'(1);
            r_k    <= i_q_index;
            r_r    <= i_q_radius;
        end else if (w_fl_step) begin
            r_wsum <= w_fl_wsum;
            r_t    <= r_t + RB'(1);
        end
    end

endmodule

### hdl/hbs_div.sv
// Division of the window sum by 2r+1 through a reciprocal multiply and one
// correction, with the output register. Depends on hbs_pkg.
module hbs_div import hbs_pkg::*; #(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_job_valid,
    output logic                                            o_job_ready,
    input  logic [COUNT_BITS+$clog2(2*MAX_RADIUS+2)-1:0]    i_job_sum,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]                 i_job_radius,
    input  logic [OUT_INDEX_BITS-1:0]                       i_job_index,
    input  logic                                            i_job_last,
    output logic                                            o_m_valid,
    input  logic                                            i_m_ready,
    output logic [OUT_COUNT_BITS-1:0]                       o_count,
    output logic [OUT_INDEX_BITS-1:0]                       o_index,
    output logic                                            o_last
);

    localparam int RB = $clog2(MAX_RADIUS + 1);
    localparam int DB = $clog2(2 * MAX_RADIUS + 2);
    localparam int SB = COUNT_BITS + DB;

    // floor(2^SB / (2r+1)) for every legal radius
    logic [SB-1:0] w_recip [MAX_RADIUS+1];
    assign w_recip[0] = '0;
    for (genvar g = 1; g <= MAX_RADIUS; g++) begin : g_recip
        localparam logic [SB:0] RECIP = {1'b1, {SB{1'b0}}} / (SB + 1)'(2 * g + 1);
        assign w_recip[g] = RECIP[SB-1:0];
    end

    logic                      r_s0_valid;
    logic [SB-1:0]             r_s0_sum;
    logic [RB-1:0]             r_s0_r;
    logic [OUT_INDEX_BITS-1:0] r_s0_index;
    logic                      r_s0_last;

    logic                      r_s1_valid;
    logic [SB-1:0]             r_s1_q0;
    logic [SB-1:0]             r_s1_sum;
    logic [DB-1:0]             r_s1_d;
    logic [OUT_INDEX_BITS-1:0] r_s1_index;
    logic                      r_s1_last;

    logic                      r_s2_valid;
    logic [OUT_COUNT_BITS-1:0] r_s2_count;
    logic [OUT_INDEX_BITS-1:0] r_s2_index;
    logic                      r_s2_last;

    logic                      w_s0_ready, w_s1_ready, w_s2_ready;
    logic [2*SB-1:0]           w_prod;
    logic [SB-1:0]             w_rem;
    logic [SB-1:0]             w_q;

    // Stall chain: a stage moves when its successor has room
    assign w_s2_ready  = !r_s2_valid || i_m_ready;
    assign w_s1_ready  = !r_s1_valid || w_s2_ready;
    assign w_s0_ready  = !r_s0_valid || w_s1_ready;
    assign o_job_ready = w_s0_ready;

    // Estimate the quotient, then correct by one where the remainder allows
    assign w_prod = (2*SB)'(r_s0_sum) * (2*SB)'(w_recip[r_s0_r]);
    assign w_rem  = r_s1_sum - SB'(r_s1_q0 * SB'(r_s1_d));
    assign w_q    = (w_rem >= SB'(r_s1_d)) ? r_s1_q0 + SB'(1) : r_s1_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s0_ready) begin
                r_s0_valid <= i_job_valid;
            end
            if (w_s1_ready) begin
                r_s1_valid <= r_s0_valid;
            end
            if (w_s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Payload of each stage
    always_ff @(posedge i_clk) begin
        if (w_s0_ready) begin
            r_s0_sum   <= i_job_sum;
            r_s0_r     <= i_job_radius;
            r_s0_index <= i_job_index;
            r_s0_last  <= i_job_last;
        end
        if (w_s1_ready) begin
            r_s1_q0    <= w_prod[2*SB-1:SB];
            r_s1_sum   <= r_s0_sum;
            r_s1_d     <= DB'({r_s0_r, 1'b1});
            r_s1_index <= r_s0_index;
            r_s1_last  <= r_s0_last;
        end
        if (w_s2_ready) begin
            r_s2_count <= OUT_COUNT_BITS'(w_q);
            r_s2_index <= r_s1_index;
            r_s2_last  <= r_s1_last;
        end
    end

    assign o_m_valid = r_s2_valid;
    assign o_count   = r_s2_count;
    assign o_index   = r_s2_index;
    assign o_last    = r_s2_last;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for histogram_box_smoothing: streams whole histograms,
// predicts every smoothed bin in step with the accepted items and checks each result.
// Depends on hbs_pkg and the histogram_box_smoothing RTL.
module testbench;
    import hbs_pkg::*;

    localparam int LINE_DEPTH    = 2 * MAX_RADIUS_DEF + 1;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic [OUT_COUNT_BITS-1:0] cnt;
        logic [OUT_INDEX_BITS-1:0] bin_idx;
        logic                      is_last;
    } t_smoothed;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_BITS-1:0]   i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;   // [23:0] bin_count
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;         // [23:0] smoothed_count, [31:24] bin_index
    logic                  m_axis_tlast;         // last

    histogram_box_smoothing dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // Bench-side copy of the smoothing state
    logic [23:0]       bin_line [LINE_DEPTH];
    logic [23:0]       edge_count     = '0;
    int                bins_seen      = 0;
    int                radius_in_use  = DEFAULT_RADIUS;
    logic [CFG_BITS-1:0] radius_reg   = CFG_BITS'(DEFAULT_RADIUS);

    t_smoothed         smoothed_due [$];
    logic [23:0]       pending_bins [$];
    logic [23:0]       corner_counts [$] = '{
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000,
        24'hAAAAAA, 24'h555555, 24'h000001, 24'hFFFFFE, 24'h800000, 24'h7FFFFF,
        24'h000002, 24'h000003, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
        24'h0F0F0F, 24'hF0F0F0, 24'h000007, 24'hFFFFF8
    };

    int          bins_queued  = 0;
    int          bins_taken   = 0;
    int          fault_count  = 0;
    int          cycle_count  = 0;
    int          burst_left   = 1;
    int          gap_left     = 0;
    int          hold_left    = 0;
    int          next_hold_at = 180;
    int          rx_phase     = 0;

    initial begin
        foreach (bin_line[d]) bin_line[d] = '0;
    end

    // Count of bin j when bin k is the newest; out-of-range bins repeat the edges
    function automatic logic [23:0] line_value(int j, int k);
        if (j < 0) return edge_count;
        if (j > k) return bin_line[0];
        if (k - j >= LINE_DEPTH) return '0;
        return bin_line[k - j];
    endfunction

    // Queue the smoothed value of bin i, with bin k as the newest
    task automatic push_smoothed(int i, int k);
        logic [27:0] acc;
        t_smoothed   res;
        acc = 28'(radius_in_use);
        for (int j = i - radius_in_use; j <= i + radius_in_use; j++) begin
            acc += 28'(line_value(j, k));
        end
        res.cnt     = OUT_COUNT_BITS'(acc / 28'(2 * radius_in_use + 1));
        res.bin_idx = OUT_INDEX_BITS'(i);
        res.is_last = (i == NUM_BINS_DEF - 1);
        smoothed_due.push_back(res);
    endtask

    // Advance the smoothing state by one accepted bin
    task automatic take_bin(logic [23:0] count);
        int k;
        int first;
        k = bins_seen;
        if (k == 0) begin
            radius_in_use = (radius_reg >= 1 && radius_reg <= MAX_RADIUS_DEF)
                          ? int'(radius_reg) : DEFAULT_RADIUS;
            edge_count = count;
        end
        for (int d = LINE_DEPTH - 1; d > 0; d--) bin_line[d] = bin_line[d - 1];
        bin_line[0] = count;
        if (k == NUM_BINS_DEF - 1) begin
            first = (k - radius_in_use < 0) ? 0 : k - radius_in_use;
            for (int i = first; i <= k; i++) push_smoothed(i, k);
            bins_seen = 0;
        end else begin
            if (k >= radius_in_use) push_smoothed(k - radius_in_use, k);
            bins_seen = k + 1;
        end
    endtask

    function automatic logic [23:0] random_count();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2:       return 24'($urandom_range(0, 15));
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic queue_bin(logic [23:0] count);
        pending_bins.push_back(count);
        bins_queued++;
    endtask

    // Wait until every item is taken and every result has come back
    task automatic drain();
        while (bins_taken != bins_queued || smoothed_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [CFG_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        radius_reg   = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic record_fault(string what);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, what);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: bursts of random length, random gaps, valid held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                take_bin(s_axis_tdata);
                bins_taken <= bins_taken + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_bins.size() != 0) begin
                    s_axis_tdata  <= pending_bins.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1:       gap_left = 1;
                            2:       gap_left = $urandom_range(1, 4);
                            default: gap_left = $urandom_range(5, 20);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: long hold-offs at set points, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_phase <= rx_phase + 1;
            if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (bins_taken >= next_hold_at) begin
                hold_left     <= HOLD_CYCLES;
                next_hold_at  <= next_hold_at + 580;
                m_axis_tready <= 1'b0;
            end else begin
                case ((rx_phase / 97) % 4)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1);
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (rx_phase % 3 != 0);
                endcase
            end
        end
    end

    // Check each result item against the oldest expectation
    always @(posedge i_clk) begin
        t_smoothed exp_item;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (smoothed_due.size() == 0) begin
                record_fault($sformatf("unexpected result: count %h bin %0d last %b",
                    m_axis_tdata[23:0], m_axis_tdata[31:24], m_axis_tlast));
            end else begin
                exp_item = smoothed_due.pop_front();
                if (m_axis_tdata[23:0] !== exp_item.cnt ||
                    m_axis_tdata[31:24] !== exp_item.bin_idx ||
                    m_axis_tlast !== exp_item.is_last) begin
                    record_fault($sformatf(
                        "mismatch: expected count %h bin %0d last %b, got count %h bin %0d last %b",
                        exp_item.cnt, exp_item.bin_idx, exp_item.is_last,
                        m_axis_tdata[23:0], m_axis_tdata[31:24], m_axis_tlast));
                end
            end
        end
    end

    // Guard against a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Illegal radius before the first bin: falls back to 3
        write_radius(3'd7);

        // First histogram: corner counts, then random bins
        foreach (corner_counts[n]) queue_bin(corner_counts[n]);
        for (int b = corner_counts.size(); b < 120; b++) queue_bin(random_count());
        drain();
        // Radius change part way through; it must wait for the next histogram
        write_radius(3'd5);
        for (int b = 120; b < NUM_BINS_DEF; b++) queue_bin(random_count());
        drain();

        // Second histogram on the widest window; saturate the high edge
        for (int b = 0; b < NUM_BINS_DEF; b++) begin
            if (b >= NUM_BINS_DEF - 6) queue_bin('1);
            else queue_bin(random_count());
        end
        drain();

        if (smoothed_due.size() != 0) fault_count++;
        if (fault_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
